### src/mept_pkg.sv
`default_nettype none
package mept_pkg;

	// Tracker geometry
	localparam int COUNT_BITS = 12;
	localparam int TURN_BITS  = 8;

	// Fixed field widths
	localparam int ENC_W  = 12;
	localparam int LOAD_W = 12;
	localparam int EDGE_W = 12;
	localparam int GAIN_W = 16;
	localparam int IVL_W  = 8;
	localparam int POS_W  = 19;
	localparam int FRAC_SHIFT = 16;

	// Derived widths
	localparam int CMP_W  = (COUNT_BITS > EDGE_W) ? COUNT_BITS : EDGE_W;
	localparam int STEP_W = TURN_BITS + COUNT_BITS;
	localparam int PROD_W = STEP_W + GAIN_W + 1;
	localparam int EXT_W  = (PROD_W > POS_W + FRAC_SHIFT) ? PROD_W : POS_W + FRAC_SHIFT;

	localparam int TURN_MAX = 2 ** (TURN_BITS - 1) - 1;
	localparam int TURN_MIN = -(2 ** (TURN_BITS - 1));
	localparam int POS_MAX  = 2 ** (POS_W - 1) - 1;
	localparam int POS_MIN  = -(2 ** (POS_W - 1));

	// APB port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes
	localparam logic [1:0] REG_LOW_EDGE  = 2'd0;
	localparam logic [1:0] REG_HIGH_EDGE = 2'd1;
	localparam logic [1:0] REG_GAIN      = 2'd2;
	localparam logic [1:0] REG_INTERVAL  = 2'd3;

	// Register reset values
	localparam logic [EDGE_W-1:0] LOW_EDGE_RST  = 12'd410;
	localparam logic [EDGE_W-1:0] HIGH_EDGE_RST = 12'd3686;
	localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd32571;
	localparam logic [IVL_W-1:0]  INTERVAL_RST  = 8'd5;

	// Item commands
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_HOME   = 1'b1;

	typedef struct packed {
		logic [EDGE_W-1:0] low_edge;
		logic [EDGE_W-1:0] high_edge;
		logic [GAIN_W-1:0] gain;
		logic [IVL_W-1:0]  interval;
	} cfg_t;

	typedef struct packed {
		logic signed [TURN_BITS-1:0] turns;
		logic                        sat;
		logic                        cap;
	} trk_t;

endpackage
`default_nettype wire

### src/mept_regs.sv
`default_nettype none
module mept_regs
	import mept_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel & penable & pwrite & pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_edge  <= LOW_EDGE_RST;
			cfg_q.high_edge <= HIGH_EDGE_RST;
			cfg_q.gain      <= GAIN_RST;
			cfg_q.interval  <= INTERVAL_RST;
		end else if (wr_en) begin
			case (idx)
				REG_LOW_EDGE:  cfg_q.low_edge  <= pwdata[EDGE_W-1:0];
				REG_HIGH_EDGE: cfg_q.high_edge <= pwdata[EDGE_W-1:0];
				REG_GAIN:      cfg_q.gain      <= pwdata[GAIN_W-1:0];
				REG_INTERVAL:  cfg_q.interval  <= pwdata[IVL_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_LOW_EDGE:  prdata = DATA_W'(cfg_q.low_edge);
			REG_HIGH_EDGE: prdata = DATA_W'(cfg_q.high_edge);
			REG_GAIN:      prdata = DATA_W'(cfg_q.gain);
			REG_INTERVAL:  prdata = DATA_W'(cfg_q.interval);
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### src/mept_track.sv
`default_nettype none
module mept_track
	import mept_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  command,
	input  wire logic [COUNT_BITS-1:0] count,
	input  wire cfg_t                  cfg,
	output trk_t                       trk
);

	logic        [COUNT_BITS-1:0] prev_q;
	logic signed [TURN_BITS-1:0]  turns_q;
	logic        [IVL_W-1:0]      decim_q;

	logic [CMP_W-1:0] cnt_x, prev_x, low_x, high_x;
	logic             up, down;
	logic signed [TURN_BITS-1:0] turns_nxt;
	logic             sat;
	logic [IVL_W:0]   decim_inc;
	logic [IVL_W-1:0] decim_nxt;

	assign cnt_x  = CMP_W'(count);
	assign prev_x = CMP_W'(prev_q);
	assign low_x  = CMP_W'(cfg.low_edge);
	assign high_x = CMP_W'(cfg.high_edge);

	// Wrap detection: up wins when both tests hold
	assign up   = (cnt_x < low_x) && (prev_x > high_x);
	assign down = !up && (cnt_x > high_x) && (prev_x < low_x);

	// Saturating turn update
	always_comb begin
		turns_nxt = turns_q;
		sat       = 1'b0;
		if (up) begin
			if (turns_q == TURN_BITS'(TURN_MAX)) sat = 1'b1;
			else turns_nxt = turns_q + TURN_BITS'(1);
		end else if (down) begin
			if (turns_q == TURN_BITS'(TURN_MIN)) sat = 1'b1;
			else turns_nxt = turns_q - TURN_BITS'(1);
		end
	end

	// Decimation counter wraps at the interval; zero interval acts as one
	assign decim_inc = {1'b0, decim_q} + (IVL_W+1)'(1);
	assign decim_nxt = (decim_inc >= {1'b0, cfg.interval}) ? '0 : decim_inc[IVL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			turns_q <= '0;
			decim_q <= '0;
		end else if (adv) begin
			if (command == CMD_HOME) begin
				prev_q  <= '0;
				turns_q <= '0;
				decim_q <= '0;
			end else begin
				prev_q  <= count;
				turns_q <= turns_nxt;
				decim_q <= decim_nxt;
			end
		end
	end

	assign trk = {turns_nxt, sat, (decim_q == '0)};

endmodule
`default_nettype wire

### src/mept_scale.sv
`default_nettype none
module mept_scale
	import mept_pkg::*;
(
	input  wire logic signed [TURN_BITS-1:0]  turns,
	input  wire logic        [COUNT_BITS-1:0] count,
	input  wire logic        [GAIN_W-1:0]     gain,
	output logic signed      [POS_W-1:0]      pos
);

	logic signed [STEP_W-1:0] steps;
	logic signed [PROD_W-1:0] steps_x, gain_x, prod;
	logic signed [EXT_W-1:0]  prod_x, shifted;

	// turns * 2^COUNT_BITS + count is a plain concatenation
	assign steps   = {turns, count};
	assign steps_x = PROD_W'(steps);
	assign gain_x  = PROD_W'({1'b0, gain});
	assign prod    = steps_x * gain_x;

	// Arithmetic shift floors toward minus infinity
	assign prod_x  = EXT_W'(prod);
	assign shifted = prod_x >>> FRAC_SHIFT;

	// Clip to the output range
	always_comb begin
		if (shifted > EXT_W'(POS_MAX))      pos = POS_W'(POS_MAX);
		else if (shifted < EXT_W'(POS_MIN)) pos = POS_W'(POS_MIN);
		else                                pos = shifted[POS_W-1:0];
	end

endmodule
`default_nettype wire

### src/multiturn_encoder_position_tracker.sv
// Multi-turn encoder position tracker.
// Sample channel (sample_valid/sample_ready) takes one item per cycle unless
// stalled: a command (sample or home), a single-turn encoder count and a load
// reading. Result channel (result_valid/result_ready) returns one item per
// input item: position in mm (Q8, saturated), turn count, capture flag,
// captured load and a turn saturation flag.
// An item accepted into the input register has its result loaded into the
// output register once that register is free or drains. Throughput is one
// item per cycle while the receiver keeps up; the turn update, the 20x17
// multiply and the clip sit between the two registers.
// When the receiver stalls, the output register holds its result and the input
// register keeps one more item; sample_ready drops once both are full.
// Reset clears turns, previous count and the decimation counter, empties both
// registers and loads the APB registers with their defaults (low edge 410,
// high edge 3686, gain 32571, capture interval 5). A home command clears the
// tracking state and returns an all-zero result.
`default_nettype none
module multiturn_encoder_position_tracker
	import mept_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic        [ADDR_W-1:0]    paddr,
	input  wire logic        [DATA_W-1:0]    pwdata,
	output logic             [DATA_W-1:0]    prdata,
	output logic                             pready,
	input  wire logic                        sample_valid,
	output logic                             sample_ready,
	input  wire logic                        command,
	input  wire logic        [ENC_W-1:0]     encoder_count,
	input  wire logic        [LOAD_W-1:0]    load_sample,
	output logic                             result_valid,
	input  wire logic                        result_ready,
	output logic signed      [POS_W-1:0]     position_mm_q8,
	output logic signed      [TURN_BITS-1:0] turn_count,
	output logic                             capture,
	output logic             [LOAD_W-1:0]    captured_load,
	output logic                             turn_saturated
);

	cfg_t cfg;
	trk_t trk;

	logic                  valid_s1;
	logic                  cmd_s1;
	logic [COUNT_BITS-1:0] count_s1;
	logic [LOAD_W-1:0]     load_s1;
	logic                  valid_s2;
	logic signed [POS_W-1:0] pos;
	logic                  out_free, adv, take;

	mept_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: stage 1 moves on when the output register is free or drains
	assign out_free     = !valid_s2 || result_ready;
	assign adv          = valid_s1 && out_free;
	assign sample_ready = !valid_s1 || out_free;
	assign take         = sample_valid && sample_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1   <= command;
			count_s1 <= COUNT_BITS'(encoder_count);
			load_s1  <= load_sample;
		end
	end

	mept_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.command (cmd_s1),
		.count   (count_s1),
		.cfg     (cfg),
		.trk     (trk)
	);

	mept_scale u_scale (
		.turns (trk.turns),
		.count (count_s1),
		.gain  (cfg.gain),
		.pos   (pos)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (cmd_s1 == CMD_HOME) begin
				position_mm_q8 <= '0;
				turn_count     <= '0;
				capture        <= 1'b0;
				captured_load  <= '0;
				turn_saturated <= 1'b0;
			end else begin
				position_mm_q8 <= pos;
				turn_count     <= trk.turns;
				capture        <= trk.cap;
				captured_load  <= trk.cap ? load_s1 : '0;
				turn_saturated <= trk.sat;
			end
		end
	end

	assign result_valid = valid_s2;

endmodule
`default_nettype wire

### verif/multiturn_encoder_position_tracker_tb.sv
`timescale 1ns / 1ps
module multiturn_encoder_position_tracker_tb;
	import mept_pkg::*;

	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic              cmd;
		logic [ENC_W-1:0]  count;
		logic [LOAD_W-1:0] load;
	} enc_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0]     pos;
		logic signed [TURN_BITS-1:0] turns;
		logic                        cap;
		logic [LOAD_W-1:0]           load;
		logic                        sat;
	} trk_result_t;

	// Block ports
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	wire  [DATA_W-1:0] prdata;
	wire               pready;
	logic              sample_valid = 1'b0;
	wire               sample_ready;
	logic              command = CMD_SAMPLE;
	logic [ENC_W-1:0]  encoder_count = '0;
	logic [LOAD_W-1:0] load_sample = '0;
	wire               result_valid;
	logic              result_ready = 1'b0;
	wire signed [POS_W-1:0]     position_mm_q8;
	wire signed [TURN_BITS-1:0] turn_count;
	wire               capture;
	wire [LOAD_W-1:0]  captured_load;
	wire               turn_saturated;

	// Testbench state
	enc_item_t   pend_q[$];
	trk_result_t pos_expect_q[$];
	enc_item_t   drv_item;
	trk_result_t want, got;
	cfg_t        cfg;
	logic [ENC_W-1:0] prev_count;
	int          turn_acc;
	logic [IVL_W-1:0] decim_count;
	bit          idling = 1'b1;
	int          src_gap, sink_gap;
	int          cycles, mismatches;
	int          n_items, n_homes, n_results, n_capt, n_sat;

	multiturn_encoder_position_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.sample_valid(sample_valid), .sample_ready(sample_ready),
		.command(command), .encoder_count(encoder_count), .load_sample(load_sample),
		.result_valid(result_valid), .result_ready(result_ready),
		.position_mm_q8(position_mm_q8), .turn_count(turn_count), .capture(capture),
		.captured_load(captured_load), .turn_saturated(turn_saturated)
	);

	always #10 clk = ~clk;

	// Tracker prediction: wrap detection, saturating turns, Q8 position, decimation
	function automatic trk_result_t track_step(input enc_item_t it);
		trk_result_t r;
		longint steps, pos;
		int nxt;
		r = '0;
		if (it.cmd == CMD_HOME) begin
			turn_acc = 0;
			prev_count = '0;
			decim_count = '0;
			return r;
		end
		if (it.count < cfg.low_edge && prev_count > cfg.high_edge) begin
			if (turn_acc >= TURN_MAX) r.sat = 1'b1;
			else turn_acc++;
		end else if (it.count > cfg.high_edge && prev_count < cfg.low_edge) begin
			if (turn_acc <= TURN_MIN) r.sat = 1'b1;
			else turn_acc--;
		end
		prev_count = it.count;
		steps = longint'(turn_acc) * (longint'(1) << COUNT_BITS) + longint'(it.count);
		// arithmetic shift of a signed product floors toward minus infinity
		pos = (steps * longint'(cfg.gain)) >>> FRAC_SHIFT;
		if (pos > POS_MAX) pos = POS_MAX;
		if (pos < POS_MIN) pos = POS_MIN;
		r.pos = pos[POS_W-1:0];
		r.turns = turn_acc[TURN_BITS-1:0];
		r.cap = (decim_count == 0);
		r.load = r.cap ? it.load : '0;
		nxt = int'(decim_count) + 1;
		if (nxt >= int'(cfg.interval)) nxt = 0;
		decim_count = nxt[IVL_W-1:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input trk_result_t w, input trk_result_t g);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s) cycle %0d: exp pos=%0d turns=%0d cap=%0b load=%0d sat=%0b",
				what, cycles, w.pos, w.turns, w.cap, w.load, w.sat,
				" | got pos=%0d turns=%0d cap=%0b load=%0d sat=%0b",
				g.pos, g.turns, g.cap, g.load, g.sat);
	endtask

	task automatic push_item(input logic cmd, input logic [ENC_W-1:0] cnt,
			input logic [LOAD_W-1:0] ld);
		enc_item_t it;
		it = '{cmd, cnt, ld};
		pend_q = {pend_q, it};
	endtask

	function automatic bit wrap_ok();
		return cfg.low_edge > 0 && cfg.high_edge < 12'hFFF && cfg.low_edge <= cfg.high_edge;
	endfunction

	// Well-formed turns: mid-range, then across the wrap in the chosen direction
	task automatic push_turns(input int n, input bit up);
		logic [ENC_W-1:0] mid, hi, lo;
		for (int k = 0; k < n; k++) begin
			mid = ENC_W'($urandom_range(cfg.low_edge, cfg.high_edge));
			hi = ENC_W'($urandom_range(cfg.high_edge + 1, 4095));
			lo = ENC_W'($urandom_range(0, cfg.low_edge - 1));
			push_item(CMD_SAMPLE, mid, LOAD_W'($urandom));
			push_item(CMD_SAMPLE, up ? hi : lo, LOAD_W'($urandom));
			push_item(CMD_SAMPLE, up ? lo : hi, LOAD_W'($urandom));
		end
	endtask

	// Mostly turn runs biased one way, some raw samples and rare home commands
	task automatic push_mixed(input int n, input bit up_bias);
		int left, sel, run;
		left = n;
		while (left > 0) begin
			sel = $urandom_range(0, 99);
			if (sel < 3) begin
				push_item(CMD_HOME, ENC_W'($urandom), LOAD_W'($urandom));
				left--;
			end else if (sel < 55 && wrap_ok()) begin
				run = $urandom_range(1, 12);
				push_turns(run, ($urandom_range(0, 9) < 7) ? up_bias : !up_bias);
				left -= 3 * run;
			end else begin
				push_item(CMD_SAMPLE, ENC_W'($urandom), LOAD_W'($urandom));
				left--;
			end
		end
	endtask

	// Setup cycle, access cycle; register takes the value at the access edge
	task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LOW_EDGE: cfg.low_edge = val[EDGE_W-1:0];
			REG_HIGH_EDGE: cfg.high_edge = val[EDGE_W-1:0];
			REG_GAIN: cfg.gain = val[GAIN_W-1:0];
			REG_INTERVAL: cfg.interval = val[IVL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
			input logic [DATA_W-1:0] gain, input logic [DATA_W-1:0] ivl);
		reg_write(REG_LOW_EDGE, lo);
		reg_write(REG_HIGH_EDGE, hi);
		reg_write(REG_GAIN, gain);
		reg_write(REG_INTERVAL, ivl);
	endtask

	// Wait until every item is in and every result is out, then let the pipe settle
	task automatic drain();
		while (pend_q.size() != 0 || sample_valid || pos_expect_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Item driver with random source idling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			src_gap <= 0;
		end else if (!sample_valid || sample_ready) begin
			if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				sample_valid <= 1'b0;
			end else if (idling && $urandom_range(0, 15) == 0) begin
				src_gap <= $urandom_range(0, 11);
				sample_valid <= 1'b0;
			end else if (pend_q.size() != 0) begin
				drv_item = pend_q.pop_front();
				sample_valid <= 1'b1;
				command <= drv_item.cmd;
				encoder_count <= drv_item.count;
				load_sample <= drv_item.load;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// Predict on every accepted item
	always @(posedge clk) begin
		if (arst_n && sample_valid && sample_ready) begin
			pos_expect_q = {pos_expect_q, track_step({command, encoder_count, load_sample})};
			n_items++;
			if (command == CMD_HOME) n_homes++;
		end
	end

	// Result monitor with random receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (result_valid && result_ready) begin
				got = {position_mm_q8, turn_count, capture, captured_load, turn_saturated};
				n_results++;
				if (got.cap) n_capt++;
				if (got.sat) n_sat++;
				if (pos_expect_q.size() == 0) begin
					flag_mismatch("no result expected", '0, got);
				end else begin
					want = pos_expect_q.pop_front();
					if (got !== want) flag_mismatch("field", want, got);
				end
			end
			if (sink_gap != 0) begin
				sink_gap <= sink_gap - 1;
				result_ready <= 1'b0;
			end else if (idling && $urandom_range(0, 15) == 0) begin
				sink_gap <= $urandom_range(0, 11);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL multiturn_encoder_position_tracker");
			$finish;
		end
	end

	initial begin
		cfg = '{LOW_EDGE_RST, HIGH_EDGE_RST, GAIN_RST, INTERVAL_RST};
		prev_count = '0;
		turn_acc = 0;
		decim_count = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed at reset settings: field extremes, strict edge tests, home
		push_item(CMD_SAMPLE, 12'd0, 12'd0);
		push_item(CMD_SAMPLE, 12'd4095, 12'd4095);   // turn down, negative position
		push_item(CMD_SAMPLE, 12'd0, 12'hAAA);       // turn back up
		push_item(CMD_SAMPLE, 12'd3686, 12'h555);    // equal to high edge: no turn
		push_item(CMD_SAMPLE, 12'd409, 12'd1);       // previous not above high edge
		push_item(CMD_SAMPLE, 12'd3687, 12'd2);      // turn down
		push_item(CMD_SAMPLE, 12'd410, 12'd3);       // equal to low edge: no turn
		push_item(CMD_SAMPLE, 12'd3687, 12'd4);      // previous not below low edge
		push_item(CMD_SAMPLE, 12'd409, 12'd5);       // turn up
		push_item(CMD_HOME, 12'd1234, 12'hFFF);
		push_item(CMD_SAMPLE, 12'd2048, 12'h555);
		push_item(CMD_HOME, 12'd4095, 12'd7);
		push_item(CMD_SAMPLE, 12'd4095, 12'hAAA);    // down right after home
		push_item(CMD_SAMPLE, 12'd4095, 12'hFFF);
		push_item(CMD_HOME, 12'd0, 12'd0);

		// Run the turn count into both limits
		push_turns(130, 1'b1);
		push_item(CMD_HOME, ENC_W'($urandom), LOAD_W'($urandom));
		push_turns(130, 1'b0);
		drain();

		// Widest edges (no wrap possible), top gain, longest interval
		set_config(32'd0, 32'd4095, 32'd65535, 32'd255);
		push_mixed(100, 1'($urandom_range(0, 1)));
		drain();

		// Crossed edges, unit gain, interval lowered below the running counter
		set_config(32'd4095, 32'd0, 32'd1, 32'd3);
		push_mixed(150, 1'($urandom_range(0, 1)));
		drain();

		// Random edges, random gain word, interval zero
		set_config($urandom_range(1, 2000), $urandom_range(2100, 4094), $urandom, 32'd0);
		push_mixed(150, 1'($urandom_range(0, 1)));
		drain();

		// Narrowest wrap zones, top gain, capture on every sample
		set_config(32'd1, 32'd4094, 32'd65535, 32'd1);
		push_mixed(150, 1'($urandom_range(0, 1)));
		drain();

		// Back to reset settings, no idling on either side
		set_config(DATA_W'(LOW_EDGE_RST), DATA_W'(HIGH_EDGE_RST), DATA_W'(GAIN_RST),
			DATA_W'(INTERVAL_RST));
		idling <= 1'b0;
		push_mixed(120, 1'($urandom_range(0, 1)));
		drain();

		while (pos_expect_q.size() != 0) begin
			flag_mismatch("missing result", pos_expect_q.pop_front(), '0);
		end
		$display("%0d items accepted (%0d home), %0d results checked, %0d captured, %0d clipped",
			n_items, n_homes, n_results, n_capt, n_sat);
		$display("six register settings: edge extremes, crossed edges, gain 1..65535, interval 0/1/255");
		if (mismatches == 0) begin
			$display("PASS multiturn_encoder_position_tracker");
		end else begin
			$display("FAIL multiturn_encoder_position_tracker");
		end
		$finish;
	end

endmodule

### filelist.f
src/mept_pkg.sv
src/mept_regs.sv
src/mept_track.sv
src/mept_scale.sv
src/multiturn_encoder_position_tracker.sv
verif/multiturn_encoder_position_tracker_tb.sv
